// ===== src/fss_pkg.sv =====
package fss_pkg;

    // default capacities
    localparam int MAX_QUERY_DEF  = 32;
    localparam int MAX_TARGET_DEF = 64;

    // result and accumulator widths (sized for the default query capacity)
    localparam int SCORE_W = 12;
    localparam int ACC_W   = 14;
    localparam int SQ_W    = 13;
    localparam int CHAR_W  = 8;
    localparam int MISS_W  = 2;

    // scoring constants
    localparam int MISS_LIMIT   = 2;
    localparam int MISS_PENALTY = 20;
    localparam int WORD_BONUS   = 8;
    localparam int FULL_BONUS   = 100;

    localparam logic signed [ACC_W-1:0] SCORE_HI = ACC_W'(2 ** (SCORE_W - 1) - 1);
    localparam logic signed [ACC_W-1:0] SCORE_LO = ACC_W'(-(2 ** (SCORE_W - 1)));

    // item kinds
    localparam logic OP_QUERY  = 1'b0;
    localparam logic OP_TARGET = 1'b1;

    // character codes
    localparam logic [CHAR_W-1:0] CH_SLASH  = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_BSLASH = 8'h5C;
    localparam logic [CHAR_W-1:0] CH_DASH   = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_USCORE = 8'h5F;
    localparam logic [CHAR_W-1:0] CH_DOT    = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [CHAR_W-1:0] CH_UP_A   = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UP_Z   = 8'h5A;
    localparam logic [CHAR_W-1:0] CASE_OFS  = 8'h20;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic start;
        logic qrd;
        logic seek;
        logic acc;
        logic fin;
        logic out_load;
    } t_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic tgt_last;
        logic q_empty;
        logic seek_done;
        logic acc_stop;
    } t_stat;

    function automatic logic is_upper(input logic [CHAR_W-1:0] c);
        return (c >= CH_UP_A) && (c <= CH_UP_Z);
    endfunction

    function automatic logic [CHAR_W-1:0] lower_byte(input logic [CHAR_W-1:0] c);
        return is_upper(c) ? c + CASE_OFS : c;
    endfunction

    function automatic logic is_sep(input logic [CHAR_W-1:0] c);
        return (c == CH_SLASH) || (c == CH_BSLASH) || (c == CH_DASH) ||
               (c == CH_USCORE) || (c == CH_DOT) || (c == CH_SPACE);
    endfunction

    // score of one finished run: length squared plus bonuses
    function automatic logic signed [ACC_W-1:0] run_score(
        input logic [SQ_W-1:0] sq,
        input logic            ws,
        input logic            full
    );
        logic signed [ACC_W-1:0] s;
        s = $signed(ACC_W'(sq));
        if (ws) begin
            s = s + $signed(ACC_W'(WORD_BONUS));
        end
        if (full) begin
            s = s + $signed(ACC_W'(FULL_BONUS));
        end
        return s;
    endfunction

endpackage

// ===== src/fss_ram.sv =====
module fss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // single write port, registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== src/fss_ctrl.sv =====
module fss_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output fss_pkg::t_cmd o_cmd,
    input  fss_pkg::t_stat i_stat
);

    import fss_pkg::*;

    localparam logic [2:0] S_LOAD = 3'd0;
    localparam logic [2:0] S_QRD  = 3'd1;
    localparam logic [2:0] S_SEEK = 3'd2;
    localparam logic [2:0] S_ACC  = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       in_ready;
    t_cmd       cmd;

    // sequencing of load, seek and score steps
    always_comb begin
        n_state  = r_state;
        cmd      = '0;
        in_ready = (r_state == S_LOAD);
        unique case (r_state)
            S_LOAD: begin
                if (i_in_valid) begin
                    cmd.load = 1'b1;
                    if (i_stat.tgt_last) begin
                        cmd.start = 1'b1;
                        n_state   = i_stat.q_empty ? S_FIN : S_QRD;
                    end
                end
            end
            S_QRD: begin
                cmd.qrd = 1'b1;
                n_state = S_SEEK;
            end
            S_SEEK: begin
                cmd.seek = 1'b1;
                if (i_stat.seek_done) begin
                    n_state = S_ACC;
                end
            end
            S_ACC: begin
                cmd.acc = 1'b1;
                n_state = i_stat.acc_stop ? S_FIN : S_QRD;
            end
            S_FIN: begin
                cmd.fin = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    cmd.out_load = 1'b1;
                    n_state      = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    // result register valid
    assign n_out_valid = cmd.out_load | (r_out_valid & ~i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = in_ready;
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

endmodule

// ===== src/fss_dp.sv =====
module fss_dp #(
    parameter int MAX_QUERY  = fss_pkg::MAX_QUERY_DEF,
    parameter int MAX_TARGET = fss_pkg::MAX_TARGET_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  fss_pkg::t_cmd                      i_cmd,
    output fss_pkg::t_stat                     o_stat,
    input  logic                               i_op,
    input  logic [fss_pkg::CHAR_W-1:0]         i_char_code,
    input  logic                               i_last,
    output logic signed [fss_pkg::SCORE_W-1:0] o_score,
    output logic                               o_no_match,
    output logic                               o_truncated
);

    import fss_pkg::*;

    localparam int QL_W = $clog2(MAX_QUERY + 1);
    localparam int QA_W = (MAX_QUERY > 1) ? $clog2(MAX_QUERY) : 1;
    localparam int TL_W = $clog2(MAX_TARGET + 1);
    localparam int TA_W = (MAX_TARGET > 1) ? $clog2(MAX_TARGET) : 1;
    localparam int TD_W = CHAR_W + 1;

    // string bookkeeping
    logic [QL_W-1:0]   r_qlen;
    logic              r_closed;
    logic              r_qovf;
    logic [TL_W-1:0]   r_tlen;
    logic              r_tovf;
    logic [CHAR_W-1:0] r_prev_ch;

    // scoring state
    logic [QL_W-1:0]         r_qi;
    logic [TL_W-1:0]         r_off;
    logic [TL_W-1:0]         r_ti;
    logic [MISS_W-1:0]       r_miss;
    logic                    r_in_run;
    logic                    r_any;
    logic                    r_fail;
    logic [QL_W-1:0]         r_run_len;
    logic [SQ_W-1:0]         r_sq;
    logic                    r_run_ws;
    logic signed [ACC_W-1:0] r_total;
    logic                    r_hit;
    logic [TL_W-1:0]         r_pos;
    logic                    r_pos_ws;

    logic [QL_W-1:0]         q_eff_len;
    logic                    q_we;
    logic [CHAR_W-1:0]       q_rdata;
    logic                    t_we;
    logic                    t_ws;
    logic [TD_W-1:0]         t_rdata;
    logic [TL_W-1:0]         t_rd_idx;
    logic                    t_end;
    logic                    t_match;
    logic                    miss_out;
    logic                    new_run;
    logic signed [ACC_W-1:0] cur_run;
    logic signed [ACC_W-1:0] penalty;
    logic signed [ACC_W-1:0] sat;

    // write side: query bytes restart the store after a closed query
    assign q_eff_len = r_closed ? '0 : r_qlen;
    assign q_we      = i_cmd.load && (i_op == OP_QUERY) && (q_eff_len < QL_W'(MAX_QUERY));
    assign t_we      = i_cmd.load && (i_op == OP_TARGET) && (r_tlen < TL_W'(MAX_TARGET));

    // word start flag is kept with each target byte
    assign t_ws = (r_tlen == '0) || is_sep(r_prev_ch) ||
                  (is_upper(i_char_code) && !is_upper(r_prev_ch));

    fss_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (MAX_QUERY)
    ) u_qram (
        .i_clk   (i_clk),
        .i_we    (q_we),
        .i_waddr (q_eff_len[QA_W-1:0]),
        .i_wdata (i_char_code),
        .i_raddr (r_qi[QA_W-1:0]),
        .o_rdata (q_rdata)
    );

    assign t_rd_idx = i_cmd.qrd ? r_off : r_ti + TL_W'(1);

    fss_ram #(
        .WIDTH (TD_W),
        .DEPTH (MAX_TARGET)
    ) u_tram (
        .i_clk   (i_clk),
        .i_we    (t_we),
        .i_waddr (r_tlen[TA_W-1:0]),
        .i_wdata ({t_ws, lower_byte(i_char_code)}),
        .i_raddr (t_rd_idx[TA_W-1:0]),
        .o_rdata (t_rdata)
    );

    // seek compare against the current query byte
    assign t_end   = (r_ti >= r_tlen);
    assign t_match = !t_end && (t_rdata[CHAR_W-1:0] == q_rdata);

    assign miss_out = !r_hit && (r_miss == MISS_W'(MISS_LIMIT));
    assign new_run  = !r_in_run || (r_off != r_pos);
    assign cur_run  = run_score(r_sq, r_run_ws, r_run_len == r_qlen);
    assign penalty  = $signed(ACC_W'(MISS_PENALTY)) * $signed(ACC_W'(r_miss));

    always_comb begin
        if (r_total > SCORE_HI) begin
            sat = SCORE_HI;
        end else if (r_total < SCORE_LO) begin
            sat = SCORE_LO;
        end else begin
            sat = r_total;
        end
    end

    assign o_stat.tgt_last  = (i_op == OP_TARGET) && i_last;
    assign o_stat.q_empty   = (r_qlen == '0);
    assign o_stat.seek_done = t_end || t_match;
    assign o_stat.acc_stop  = miss_out || ((r_qi + QL_W'(1)) == r_qlen);

    // string lengths and overflow flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qlen   <= '0;
            r_closed <= 1'b1;
            r_qovf   <= 1'b0;
            r_tlen   <= '0;
            r_tovf   <= 1'b0;
        end else if (i_cmd.load) begin
            if (i_op == OP_QUERY) begin
                if (q_we) begin
                    r_qlen <= q_eff_len + QL_W'(1);
                end else begin
                    r_qlen <= q_eff_len;
                end
                r_qovf   <= (r_qovf && !r_closed) || !q_we;
                r_closed <= i_last;
            end else begin
                if (t_we) begin
                    r_tlen <= r_tlen + TL_W'(1);
                end else begin
                    r_tovf <= 1'b1;
                end
            end
        end else if (i_cmd.out_load) begin
            r_tlen <= '0;
            r_tovf <= 1'b0;
        end
    end

    // scoring registers and result
    always_ff @(posedge i_clk) begin
        if (t_we) begin
            r_prev_ch <= i_char_code;
        end
        if (i_cmd.start) begin
            r_qi     <= '0;
            r_off    <= '0;
            r_miss   <= '0;
            r_in_run <= 1'b0;
            r_any    <= 1'b0;
            r_fail   <= 1'b0;
            r_total  <= '0;
        end
        if (i_cmd.qrd) begin
            r_ti <= r_off;
        end
        if (i_cmd.seek) begin
            if (t_end || t_match) begin
                r_hit    <= t_match;
                r_pos    <= r_ti;
                r_pos_ws <= t_rdata[CHAR_W];
            end else begin
                r_ti <= r_ti + TL_W'(1);
            end
        end
        if (i_cmd.acc) begin
            r_qi <= r_qi + QL_W'(1);
            if (r_hit) begin
                if (new_run) begin
                    if (r_in_run) begin
                        r_total <= r_total + cur_run;
                    end
                    r_run_len <= QL_W'(1);
                    r_sq      <= SQ_W'(1);
                    r_run_ws  <= r_pos_ws;
                    r_in_run  <= 1'b1;
                    r_any     <= 1'b1;
                end else begin
                    r_run_len <= r_run_len + QL_W'(1);
                    r_sq      <= r_sq + (SQ_W'(r_run_len) << 1) + SQ_W'(1);
                end
                r_off <= r_pos + TL_W'(1);
            end else begin
                r_miss <= r_miss + MISS_W'(1);
                if (miss_out) begin
                    r_fail <= 1'b1;
                end
            end
        end
        if (i_cmd.fin) begin
            r_total <= r_total + (r_in_run ? cur_run : '0) - penalty;
            r_fail  <= r_fail || !r_any;
        end
        if (i_cmd.out_load) begin
            o_score     <= r_fail ? '0 : sat[SCORE_W-1:0];
            o_no_match  <= r_fail;
            o_truncated <= r_qovf || r_tovf;
        end
    end

endmodule

// ===== src/fuzzy_subsequence_score.sv =====
// Fuzzy subsequence scorer. Query bytes (op 0) and target bytes (op 1) are taken one item
// per cycle while loading; the query is kept until a new one starts after a byte marked
// last. A target byte marked last starts scoring, during which no item is taken: for each
// query byte the target store is read one position per cycle from the current offset.
// The input stays stalled while each query byte is read, sought and scored in turn
// (states QRD, SEEK, ACC), then through FIN and DONE; handling stops at the third missed
// byte. The positions examined come to at most one pass over the target plus one pass per
// missed byte; the target memory has a single read port. One result item follows each
// target; it sits in an output register, and loading of the next strings goes on while
// it waits to be taken; the stall after the next target lasts until the waiting item
// has been taken.
module fuzzy_subsequence_score #(
    parameter int MAX_QUERY  = fss_pkg::MAX_QUERY_DEF,
    parameter int MAX_TARGET = fss_pkg::MAX_TARGET_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic                               i_op,
    input  logic [fss_pkg::CHAR_W-1:0]         i_char_code,
    input  logic                               i_last,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic signed [fss_pkg::SCORE_W-1:0] o_score,
    output logic                               o_no_match,
    output logic                               o_truncated
);

    import fss_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // sequencer
    fss_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    // stores, seek and score arithmetic
    fss_dp #(
        .MAX_QUERY  (MAX_QUERY),
        .MAX_TARGET (MAX_TARGET)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_op        (i_op),
        .i_char_code (i_char_code),
        .i_last      (i_last),
        .o_score     (o_score),
        .o_no_match  (o_no_match),
        .o_truncated (o_truncated)
    );

endmodule

// ===== src/fss_checker.sv =====
module fss_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_in_valid,
    input logic                               o_in_ready,
    input logic                               i_op,
    input logic [fss_pkg::CHAR_W-1:0]         i_char_code,
    input logic                               i_last,
    input logic                               o_out_valid,
    input logic                               i_out_ready,
    input logic signed [fss_pkg::SCORE_W-1:0] o_score,
    input logic                               o_no_match,
    input logic                               o_truncated
);

    import fss_pkg::*;

    // no result item straight after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // a failed match carries a zero score
    a_nomatch_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_no_match |-> o_score == '0)
        else $error("non-zero score with no match");

    // a waiting result item holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_score) &&
            $stable(o_no_match) && $stable(o_truncated))
        else $error("result item changed while stalled");

    // input stalls only after a target item marked last was taken
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_in_ready) |-> $past(i_in_valid && (i_op == OP_TARGET) && i_last))
        else $error("input stalled without a finished target");

endmodule

bind fuzzy_subsequence_score fss_checker u_fss_checker (.*);

// ===== sim/tb_fuzzy_subsequence_score.sv =====
module tb_fuzzy_subsequence_score;
    timeunit 1ns;
    timeprecision 1ps;

    import fss_pkg::*;

    localparam int QCAP         = MAX_QUERY_DEF;
    localparam int TCAP         = MAX_TARGET_DEF;
    localparam int N_RANDOM     = 1800;
    localparam int DRAIN_CYCLES = 600;
    localparam int HOLD_CYCLES  = 400;
    localparam int SAT_HI       = (1 << (SCORE_W - 1)) - 1;
    localparam int SAT_LO       = -(1 << (SCORE_W - 1));
    localparam logic [CHAR_W-1:0] LOW_A = 8'h61;
    localparam logic [CHAR_W-1:0] LOW_Z = 8'h7A;
    localparam logic [CHAR_W-1:0] DIG_0 = 8'h30;

    typedef struct packed {
        logic              op;
        logic [CHAR_W-1:0] ch;
        logic              last;
    } char_item_t;

    typedef struct packed {
        logic [SCORE_W-1:0] score;
        logic               no_match;
        logic               truncated;
    } score_res_t;

    logic                      i_clk       = 1'b0;
    logic                      i_rst_n     = 1'b0;
    logic                      i_in_valid  = 1'b0;
    logic                      o_in_ready;
    logic                      i_op        = OP_QUERY;
    logic [CHAR_W-1:0]         i_char_code = '0;
    logic                      i_last      = 1'b0;
    logic                      o_out_valid;
    logic                      i_out_ready = 1'b0;
    logic signed [SCORE_W-1:0] o_score;
    logic                      o_no_match;
    logic                      o_truncated;

    fuzzy_subsequence_score DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_op        (i_op),
        .i_char_code (i_char_code),
        .i_last      (i_last),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_score     (o_score),
        .o_no_match  (o_no_match),
        .o_truncated (o_truncated)
    );

    // predictor state: query and target stores as the block should hold them
    logic [CHAR_W-1:0] qry_mem [QCAP];
    int                qry_len    = 0;
    bit                qry_closed = 1'b1;
    bit                qry_ovf    = 1'b0;
    logic [CHAR_W-1:0] tgt_mem [TCAP];
    int                tgt_len    = 0;
    bit                tgt_ovf    = 1'b0;

    score_res_t score_q[$];
    char_item_t send_q[$];

    // stimulus planning: query text as sent, for building matching targets
    logic [CHAR_W-1:0] qry_plan[$];
    bit                plan_open = 1'b0;

    int n_pushed    = 0;
    int n_accepted  = 0;
    int n_qry_items = 0;
    int n_tgt_items = 0;
    int n_checked   = 0;
    int n_nomatch   = 0;
    int n_trunc     = 0;
    int n_errors    = 0;

    char_item_t shown;
    score_res_t want;
    int         burst_left = 1;
    int         gap_left   = 0;
    int         rx_mode    = 0;
    int         rx_left    = 0;
    int         rx_tick    = 0;
    logic       rx_pick;
    logic       long_hold  = 1'b0;

    // clock and reset
    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // run limit
    initial begin
        #4_000_000;
        $display("TB_ERROR");
        $finish;
    end

    task automatic report_error(input string msg);
        n_errors++;
        if (n_errors <= 40) begin
            $display("[%0t] mismatch: %s", $time, msg);
        end
    endtask

    function automatic bit upper_ch(input logic [CHAR_W-1:0] c);
        return (c >= CH_UP_A) && (c <= CH_UP_Z);
    endfunction

    function automatic logic [CHAR_W-1:0] fold_ch(input logic [CHAR_W-1:0] c);
        return upper_ch(c) ? c + CASE_OFS : c;
    endfunction

    // word start: index 0, after a separator, or a capital after a non-capital
    function automatic bit word_head(input int idx);
        logic [CHAR_W-1:0] prev;
        if (idx == 0) return 1'b1;
        if (idx >= tgt_len) return 1'b0;
        prev = tgt_mem[idx - 1];
        if (prev == CH_SLASH || prev == CH_BSLASH || prev == CH_DASH ||
            prev == CH_USCORE || prev == CH_DOT || prev == CH_SPACE) begin
            return 1'b1;
        end
        return upper_ch(tgt_mem[idx]) && !upper_ch(prev);
    endfunction

    function automatic int find_from(input logic [CHAR_W-1:0] c, input int from);
        for (int i = from; i < tgt_len; i++) begin
            if (fold_ch(tgt_mem[i]) == c) return i;
        end
        return tgt_len;
    endfunction

    function automatic int run_points(input int start, input int len);
        int s;
        s = len * len;
        if (word_head(start)) s += WORD_BONUS;
        if (len == qry_len) s += FULL_BONUS;
        return s;
    endfunction

    // greedy left-to-right search of each query byte; returns 0 on no match
    function automatic bit match_score(output int total);
        int offset, seg_start, run_len, misses, pos;
        bit in_run, any_run;
        offset    = 0;
        seg_start = 0;
        run_len   = 0;
        misses    = 0;
        in_run    = 1'b0;
        any_run   = 1'b0;
        total     = 0;
        if (qry_len == 0) return 1'b0;
        for (int i = 0; i < qry_len; i++) begin
            pos = find_from(qry_mem[i], offset);
            if (pos >= tgt_len) begin
                misses++;
                if (misses > MISS_LIMIT) return 1'b0;
            end else begin
                if (!in_run || offset != pos) begin
                    if (in_run) total += run_points(seg_start, run_len);
                    seg_start = pos;
                    run_len   = 1;
                    in_run    = 1'b1;
                    any_run   = 1'b1;
                end else begin
                    run_len++;
                end
                offset = pos + 1;
            end
        end
        if (in_run) total += run_points(seg_start, run_len);
        if (!any_run) return 1'b0;
        total -= MISS_PENALTY * misses;
        return 1'b1;
    endfunction

    // update the predicted stores with one accepted item; a closing target byte
    // queues the expected score
    function automatic void take_char(input char_item_t it);
        int         total;
        bit         hit;
        score_res_t r;
        if (it.op == OP_QUERY) begin
            if (qry_closed) begin
                qry_len    = 0;
                qry_ovf    = 1'b0;
                qry_closed = 1'b0;
            end
            if (qry_len < QCAP) begin
                qry_mem[qry_len] = it.ch;
                qry_len++;
            end else begin
                qry_ovf = 1'b1;
            end
            if (it.last) qry_closed = 1'b1;
            return;
        end
        if (tgt_len < TCAP) begin
            tgt_mem[tgt_len] = it.ch;
            tgt_len++;
        end else begin
            tgt_ovf = 1'b1;
        end
        if (!it.last) return;
        hit = match_score(total);
        if (!hit) begin
            total = 0;
        end else if (total > SAT_HI) begin
            total = SAT_HI;
        end else if (total < SAT_LO) begin
            total = SAT_LO;
        end
        r.score     = SCORE_W'(total);
        r.no_match  = !hit;
        r.truncated = qry_ovf || tgt_ovf;
        score_q     = {score_q, r};
        tgt_len = 0;
        tgt_ovf = 1'b0;
    endfunction

    task automatic push_char(input logic op, input logic [CHAR_W-1:0] ch, input logic last);
        char_item_t it;
        it.op   = op;
        it.ch   = ch;
        it.last = last;
        send_q  = {send_q, it};
        n_pushed++;
    endtask

    task automatic push_text(input logic op, input string s);
        for (int i = 0; i < s.len(); i++) begin
            push_char(op, s[i], i == s.len() - 1);
        end
    endtask

    // filler byte for targets: separators, capitals, digits, lower case
    function automatic logic [CHAR_W-1:0] filler();
        case ($urandom_range(0, 5))
            0: begin
                case ($urandom_range(0, 5))
                    0: return CH_SLASH;
                    1: return CH_BSLASH;
                    2: return CH_DASH;
                    3: return CH_USCORE;
                    4: return CH_DOT;
                    default: return CH_SPACE;
                endcase
            end
            1: return CH_UP_A + CHAR_W'($urandom_range(0, 25));
            2: return DIG_0 + CHAR_W'($urandom_range(0, 9));
            default: return LOW_A + CHAR_W'($urandom_range(0, 25));
        endcase
    endfunction

    // mostly short queries, a few long ones and a few that overflow;
    // now and then the query is left open
    task automatic plan_query();
        int                n, r;
        bit                open_now;
        logic [CHAR_W-1:0] c;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            n = $urandom_range(1, 6);
        end else if (r < 92) begin
            n = $urandom_range(7, 20);
        end else if (r < 97) begin
            n = $urandom_range(21, QCAP);
        end else begin
            n = $urandom_range(QCAP + 1, QCAP + 8);
        end
        open_now = ($urandom_range(0, 15) == 0);
        if (!plan_open) qry_plan.delete();
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 9) == 0) begin
                c = CHAR_W'($urandom_range(0, 255));
            end else begin
                c = LOW_A + CHAR_W'($urandom_range(0, 25));
            end
            qry_plan = {qry_plan, c};
            push_char(OP_QUERY, c, (i == n - 1) && !open_now);
        end
        plan_open = open_now;
    endtask

    // targets built around the query with fillers, case changes and dropped
    // bytes; some pure noise and some padded past the target store
    task automatic plan_target();
        logic [CHAR_W-1:0] tq[$];
        logic [CHAR_W-1:0] c;
        int                kind, pad_to;
        kind = $urandom_range(0, 99);
        if (kind < 15) begin
            repeat ($urandom_range(1, 12)) tq = {tq, CHAR_W'($urandom_range(0, 255))};
        end else begin
            foreach (qry_plan[j]) begin
                if ($urandom_range(0, 99) >= 8) begin
                    if ($urandom_range(0, 1) == 1) begin
                        repeat ($urandom_range(1, 2)) tq = {tq, filler()};
                    end
                    c = qry_plan[j];
                    if (c >= LOW_A && c <= LOW_Z && $urandom_range(0, 9) < 3) c = c - CASE_OFS;
                    tq = {tq, c};
                end
            end
            repeat ($urandom_range(0, 2)) tq = {tq, filler()};
            if (kind < 20) begin
                pad_to = $urandom_range(TCAP + 1, TCAP + 8);
                while (tq.size() < pad_to) tq = {tq, filler()};
            end
            if (tq.size() == 0) tq = {tq, filler()};
        end
        foreach (tq[k]) push_char(OP_TARGET, tq[k], k == tq.size() - 1);
    endtask

    // sender: bursts of items separated by random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                take_char(shown);
                n_accepted++;
                if (shown.op == OP_QUERY) n_qry_items++;
                else n_tgt_items++;
            end
            if (!i_in_valid || o_in_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (send_q.size() > 0) begin
                    shown = send_q.pop_front();
                    i_op        <= shown.op;
                    i_char_code <= shown.ch;
                    i_last      <= shown.last;
                    i_in_valid  <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 30);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: checks each result and stalls in segments of varying style
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (score_q.size() == 0) begin
                    report_error($sformatf("result with nothing expected, score %0d",
                                           o_score));
                end else begin
                    want = score_q.pop_front();
                    if (o_score !== want.score) begin
                        report_error($sformatf("result %0d score expected %0d got %0d",
                                               n_checked, $signed(want.score), o_score));
                    end
                    if (o_no_match !== want.no_match) begin
                        report_error($sformatf("result %0d no_match expected %0b got %0b",
                                               n_checked, want.no_match, o_no_match));
                    end
                    if (o_truncated !== want.truncated) begin
                        report_error($sformatf("result %0d truncated expected %0b got %0b",
                                               n_checked, want.truncated, o_truncated));
                    end
                    if (want.no_match) n_nomatch++;
                    if (want.truncated) n_trunc++;
                    n_checked++;
                end
            end
            if (rx_left == 0) begin
                rx_mode = $urandom_range(0, 3);
                rx_left = $urandom_range(16, 96);
            end
            rx_left--;
            rx_tick++;
            case (rx_mode)
                0: rx_pick = 1'b1;
                1: rx_pick = $urandom_range(0, 1);
                2: rx_pick = ($urandom_range(0, 3) == 0);
                default: rx_pick = rx_tick[2];
            endcase
            i_out_ready <= rx_pick && !long_hold;
        end
    end

    // one long hold-off on the result side so that loading backs up
    initial begin
        wait (n_checked >= 40);
        @(posedge i_clk);
        long_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        long_hold <= 1'b0;
    end

    // stimulus and end of run
    initial begin
        // target before any query: empty query
        push_text(OP_TARGET, "q");
        // full match in capitals, match after a dash, no match at all
        push_text(OP_QUERY, "ab");
        push_text(OP_TARGET, "AB");
        push_text(OP_TARGET, "-ab");
        push_text(OP_TARGET, "zz");
        // target while the query is still open, then the query carries on
        push_char(OP_QUERY, 8'hFF, 1'b0);
        push_char(OP_QUERY, 8'h00, 1'b0);
        push_char(OP_TARGET, 8'hFF, 1'b1);
        push_char(OP_QUERY, 8'h7F, 1'b1);
        push_char(OP_TARGET, 8'h00, 1'b0);
        push_char(OP_TARGET, 8'h7F, 1'b1);
        // separators between matched bytes
        push_text(OP_QUERY, "cat");
        push_text(OP_TARGET, "c\\a t");
        qry_plan = '{LOW_A + 8'd2, LOW_A, LOW_A + 8'd19};

        while (n_pushed < 24 + N_RANDOM) begin
            if (qry_plan.size() == 0 || $urandom_range(0, 99) < 12) plan_query();
            plan_target();
        end

        while (n_accepted < n_pushed) @(posedge i_clk);
        while (score_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("items taken: %0d query bytes, %0d target bytes", n_qry_items, n_tgt_items);
        $display("scores checked: %0d (%0d without a match, %0d with truncation)",
                 n_checked, n_nomatch, n_trunc);
        if (n_errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== files.f =====
src/fss_pkg.sv
src/fss_ram.sv
src/fss_ctrl.sv
src/fss_dp.sv
src/fuzzy_subsequence_score.sv
src/fss_checker.sv
sim/tb_fuzzy_subsequence_score.sv
